// File: rtl/core/gdbd_pkg.sv
`timescale 1ns / 1ps

package gdbd_pkg;

  // Field widths of the date and result ports.
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  // Width of a year reduced modulo the 400-year Gregorian cycle.
  localparam int unsigned ModW   = 9;

  localparam logic [YearW-1:0]  YearMin    = YearW'(1);
  localparam logic [YearW-1:0]  YearMax    = YearW'(9999);
  localparam logic [YearW-1:0]  LeapCycle  = YearW'(400);
  localparam logic [ModW-1:0]   ModCentury1 = ModW'(100);
  localparam logic [ModW-1:0]   ModCentury2 = ModW'(200);
  localparam logic [ModW-1:0]   ModCentury3 = ModW'(300);
  localparam logic [ModW-1:0]   ModLast    = ModW'(399);

  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

  localparam logic [DayW-1:0]   DayFirst = DayW'(1);
  localparam logic [DayW-1:0]   FebLeap  = DayW'(29);
  localparam logic [DayW-1:0]   FebPlain = DayW'(28);

  // Month lengths of a common year, January first.
  localparam logic [DayW-1:0] MonthLen [12] = '{
    DayW'(31), DayW'(28), DayW'(31), DayW'(30), DayW'(31), DayW'(30),
    DayW'(31), DayW'(31), DayW'(30), DayW'(31), DayW'(30), DayW'(31)
  };

  // Year is the most significant member, so a packed compare orders dates.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef logic [ModW-1:0] ymod_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_S,
    ST_MOD_E,
    ST_CHECK,
    ST_WALK
  } state_e;

  // Leap year from the year modulo 400: divisible by 4 and not a plain century.
  function automatic logic is_leap(ymod_t ymod);
    logic century;
    century = (ymod == ModCentury1) || (ymod == ModCentury2) || (ymod == ModCentury3);
    return (ymod[1:0] == 2'b00) && !century;
  endfunction

  // Days in a month; zero for a month code outside January to December.
  function automatic logic [DayW-1:0] month_days(logic [MonthW-1:0] month, logic leap);
    logic [DayW-1:0] len;
    len = '0;
    if ((month >= MonthJan) && (month <= MonthDec)) begin
      if (month == MonthFeb) begin
        len = leap ? FebLeap : FebPlain;
      end else begin
        len = MonthLen[MonthW'(month - MonthJan)];
      end
    end
    return len;
  endfunction

  // A date is possible when year, month and day all lie in range.
  function automatic logic date_ok(date_t dt, ymod_t ymod);
    logic year_ok;
    year_ok = (dt.year >= YearMin) && (dt.year <= YearMax);
    return year_ok && (dt.day >= DayFirst) &&
           (dt.day <= month_days(dt.month, is_leap(ymod)));
  endfunction

endpackage

// File: rtl/core/gdbd_day_step.sv
`timescale 1ns / 1ps

module gdbd_day_step (
  input  gdbd_pkg::date_t cur_i,
  input  gdbd_pkg::ymod_t cur_mod_i,
  input  gdbd_pkg::date_t end_i,
  output gdbd_pkg::date_t nxt_o,
  output gdbd_pkg::ymod_t nxt_mod_o,
  output logic            before_o
);
  import gdbd_pkg::*;

  logic [DayW-1:0] last_day;

  // The working date is still short of the end date.
  assign before_o = (cur_i < end_i);

  assign last_day = month_days(cur_i.month, is_leap(cur_mod_i));

  // Advance the working date by one day, rolling month and year over.
  always_comb begin
    nxt_o     = cur_i;
    nxt_mod_o = cur_mod_i;
    if (cur_i.day == last_day) begin
      nxt_o.day = DayFirst;
      if (cur_i.month == MonthDec) begin
        nxt_o.month = MonthJan;
        nxt_o.year  = cur_i.year + YearW'(1);
        nxt_mod_o   = (cur_mod_i == ModLast) ? '0 : cur_mod_i + ModW'(1);
      end else begin
        nxt_o.month = cur_i.month + MonthW'(1);
      end
    end else begin
      nxt_o.day = cur_i.day + DayW'(1);
    end
  end

endmodule

// File: rtl/core/gregorian_days_between_dates_core.sv
`timescale 1ns / 1ps

// Gregorian day counter.
// The input channel (in_valid_i / in_ready_o) carries two dates and an
// include-end flag; the output channel (out_valid_o / out_ready_i) returns
// the day count and a flag for an impossible date, one result per input.
// One transaction is worked on at a time, and in_ready_o is high only while
// the sequencer is idle. After acceptance each year is reduced modulo 400 by
// repeated subtraction, a check state tests both dates, and then the
// day-step unit walks the working date one day per cycle until it reaches
// the end date. An impossible date ends the transaction at the check, with
// no walk and a zero count.
// The result sits in an output register; while the receiver stalls, the
// sequencer may take a new transaction and work on it, but holds its final
// step until the previous result has been taken.
// Reset returns the sequencer to idle and drops out_valid_o.
module gregorian_days_between_dates_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gdbd_pkg::DayW-1:0]    start_day_i,
  input  logic [gdbd_pkg::MonthW-1:0]  start_month_i,
  input  logic [gdbd_pkg::YearW-1:0]   start_year_i,
  input  logic [gdbd_pkg::DayW-1:0]    end_day_i,
  input  logic [gdbd_pkg::MonthW-1:0]  end_month_i,
  input  logic [gdbd_pkg::YearW-1:0]   end_year_i,
  input  logic                         include_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gdbd_pkg::CountW-1:0]  day_count_o,
  output logic                         bad_date_o
);
  import gdbd_pkg::*;

  state_e state_q, state_d;

  date_t             start_q, end_q, walk_q;
  logic              inc_q;
  logic [YearW-1:0]  red_q;
  ymod_t             s_mod_q, e_mod_q, walk_mod_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] day_count_q;
  logic              bad_q;
  logic              out_valid_q;

  date_t nxt_date;
  ymod_t nxt_mod;
  logic  short_of_end;
  logic  red_ge;
  logic  dates_ok;
  logic  out_free;
  logic  done_bad;
  logic  done_walk;

  // Day-step and compare unit for the date walk.
  gdbd_day_step u_step (
    .cur_i     (walk_q),
    .cur_mod_i (walk_mod_q),
    .end_i     (end_q),
    .nxt_o     (nxt_date),
    .nxt_mod_o (nxt_mod),
    .before_o  (short_of_end)
  );

  assign red_ge   = (red_q >= LeapCycle);
  assign dates_ok = date_ok(start_q, s_mod_q) && date_ok(end_q, e_mod_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MOD_S;
      end
      ST_MOD_S: begin
        if (!red_ge) state_d = ST_MOD_E;
      end
      ST_MOD_E: begin
        if (!red_ge) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (dates_ok) begin
          state_d = ST_WALK;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (!short_of_end && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    done_bad   = (state_q == ST_CHECK) && !dates_ok && out_free;
    done_walk  = (state_q == ST_WALK) && !short_of_end && out_free;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_bad || done_walk) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers: year reduction, date walk and day count.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          start_q <= '{year: start_year_i, month: start_month_i, day: start_day_i};
          end_q   <= '{year: end_year_i, month: end_month_i, day: end_day_i};
          inc_q   <= include_end_i;
          red_q   <= start_year_i;
        end
      end
      ST_MOD_S: begin
        if (red_ge) begin
          red_q <= red_q - LeapCycle;
        end else begin
          s_mod_q <= red_q[ModW-1:0];
          red_q   <= end_q.year;
        end
      end
      ST_MOD_E: begin
        if (red_ge) begin
          red_q <= red_q - LeapCycle;
        end else begin
          e_mod_q <= red_q[ModW-1:0];
        end
      end
      ST_CHECK: begin
        walk_q     <= start_q;
        walk_mod_q <= s_mod_q;
        count_q    <= '0;
      end
      ST_WALK: begin
        if (short_of_end) begin
          walk_q     <= nxt_date;
          walk_mod_q <= nxt_mod;
          count_q    <= count_q + CountW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register, loaded when a transaction completes.
  always_ff @(posedge clk_i) begin
    if (done_bad) begin
      day_count_q <= '0;
      bad_q       <= 1'b1;
    end else if (done_walk) begin
      day_count_q <= count_q + CountW'(inc_q);
      bad_q       <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_count_o = day_count_q;
  assign bad_date_o  = bad_q;

endmodule

// File: rtl/core/gdbd_checker.sv
`timescale 1ns / 1ps

module gdbd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [gdbd_pkg::CountW-1:0]  day_count_o,
  input logic                         bad_date_o
);
  import gdbd_pkg::*;

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(day_count_o) && $stable(bad_date_o))
    else $error("result payload changed while stalled");

  // An impossible date always reports a zero count.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_date_o |-> day_count_o == '0)
    else $error("nonzero count with bad date");

  // The block is busy in the cycle after it accepts a transaction.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a transaction");

  // No transaction completes in the cycle right after acceptance.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind gregorian_days_between_dates_core gdbd_checker u_gdbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .day_count_o (day_count_o),
  .bad_date_o  (bad_date_o)
);
